// ----- design/assert_macros.svh -----
// Assertion macros shared by the terminal cell buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/ttcb_pkg.sv -----
// Shared types and constants of the terminal cell buffer.
`timescale 1ns / 1ps
package ttcb_pkg;
    localparam int DEF_ROWS = 80;
    localparam int DEF_COLS = 160;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [2:0] PEN_DEFAULT = 3'd0;

    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_BS   = 2'd1;
    localparam logic [1:0] CMD_CLR  = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_PUT  = 3'd1;
    localparam logic [2:0] OP_BS   = 3'd2;
    localparam logic [2:0] OP_CLR  = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic       pre_esc;
        logic [7:0] data;
        logic [2:0] pen;
        logic [6:0] rd_row;
        logic [7:0] rd_col;
    } t_op;

    typedef struct packed {
        logic init_busy;
    } t_bk_status;
endpackage

// ----- design/ttcb_if.sv -----
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps
interface ttcb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [6:0] read_row;
    logic [7:0] read_col;
    modport source (output valid, cmd, data_byte, read_row, read_col, input ready);
    modport sink (input valid, cmd, data_byte, read_row, read_col, output ready);
endinterface

interface ttcb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [2:0] cell_color;
    logic [6:0] cursor_row;
    logic [7:0] cursor_col;
    modport source (output valid, cell_char, cell_color, cursor_row, cursor_col, input ready);
    modport sink (input valid, cell_char, cell_color, cursor_row, cursor_col, output ready);
endinterface

// ----- design/ttcb_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ttcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/ttcb_fifo.sv -----
// Two-entry queue between the command front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttcb_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    `ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != 2'd2)
endmodule

// ----- design/ttcb_front.sv -----
// Front end: takes command items, runs the escape parser and queues operations.
`timescale 1ns / 1ps
module ttcb_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ttcb_in_if.sink                i_in,
    input  ttcb_pkg::t_bk_status   i_status,
    input  logic                   i_q_full,
    output logic                   o_push,
    output ttcb_pkg::t_op          o_op
);
    localparam logic [1:0] ESC_IDLE    = 2'd0;
    localparam logic [1:0] ESC_SEEN    = 2'd1;
    localparam logic [1:0] ESC_BRACKET = 2'd2;

    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_W   = 8'h77;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_G   = 8'h67;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_Y   = 8'h79;
    localparam logic [7:0] CH_A   = 8'h61;

    logic [1:0]    r_phase, n_phase;
    logic [2:0]    r_pen, n_pen;
    logic          w_acc;
    ttcb_pkg::t_op w_op;

    assign i_in.ready = !i_q_full && !i_status.init_busy;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        n_phase     = r_phase;
        n_pen       = r_pen;
        w_op        = '0;
        w_op.kind   = ttcb_pkg::OP_NONE;
        w_op.data   = i_in.data_byte;
        w_op.pen    = r_pen;
        w_op.rd_row = i_in.read_row;
        w_op.rd_col = i_in.read_col;
        case (i_in.cmd)
            ttcb_pkg::CMD_PUT: begin
                if (r_phase == ESC_BRACKET) begin
                    n_phase = ESC_IDLE;
                    case (i_in.data_byte)
                        CH_W:    n_pen = 3'd0;
                        CH_R:    n_pen = 3'd1;
                        CH_G:    n_pen = 3'd2;
                        CH_B:    n_pen = 3'd3;
                        CH_Y:    n_pen = 3'd4;
                        CH_A:    n_pen = 3'd5;
                        default: n_pen = r_pen;
                    endcase
                end else if (r_phase == ESC_SEEN && i_in.data_byte == CH_LBR) begin
                    n_phase = ESC_BRACKET;
                end else begin
                    // a lone escape is printed ahead of this byte
                    w_op.pre_esc = (r_phase == ESC_SEEN);
                    if (i_in.data_byte == ttcb_pkg::CH_ESC) begin
                        n_phase = ESC_SEEN;
                    end else begin
                        n_phase   = ESC_IDLE;
                        w_op.kind = ttcb_pkg::OP_PUT;
                    end
                end
            end
            ttcb_pkg::CMD_BS: begin
                n_phase   = ESC_IDLE;
                w_op.kind = ttcb_pkg::OP_BS;
            end
            ttcb_pkg::CMD_CLR: begin
                n_phase   = ESC_IDLE;
                w_op.kind = ttcb_pkg::OP_CLR;
            end
            default: begin
                w_op.kind = ttcb_pkg::OP_READ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
            r_pen   <= ttcb_pkg::PEN_DEFAULT;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_pen   <= n_pen;
        end
    end

    assign o_push = w_acc;
    assign o_op   = w_op;
endmodule

// ----- design/ttcb_back.sv -----
// Back end: cursor, cell memory, scroll and clear sweeps, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttcb_back #(
    parameter int ROWS = ttcb_pkg::DEF_ROWS,
    parameter int COLS = ttcb_pkg::DEF_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_vis_cols,
    input  logic [6:0]            i_vis_rows,
    input  logic                  i_q_empty,
    input  ttcb_pkg::t_op         i_op,
    output logic                  o_pop,
    output ttcb_pkg::t_bk_status  o_status,
    ttcb_out_if.source            o_out
);
    localparam int RW    = $clog2(ROWS);
    localparam int CAW   = $clog2(COLS);
    localparam int CW    = $clog2(COLS + 1);
    localparam int AW    = RW + CAW;
    localparam int DEPTH = ROWS * (2 ** CAW);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHAR  = 4'd1;
    localparam logic [3:0] S_WR    = 4'd2;
    localparam logic [3:0] S_NEXT  = 4'd3;
    localparam logic [3:0] S_SWEEP = 4'd4;
    localparam logic [3:0] S_BS    = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_RDW   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]     r_state, n_state;
    logic [3:0]     r_ret, n_ret;
    ttcb_pkg::t_op  r_op, n_op;
    logic [7:0]     r_ch, n_ch;
    logic           r_main, n_main;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_base, n_base;
    logic [RW-1:0]  r_sw_row, n_sw_row;
    logic [CAW-1:0] r_sw_col, n_sw_col;
    logic           r_sw_all, n_sw_all;
    logic           r_init, n_init;
    logic [7:0]     r_res_ch, n_res_ch;
    logic [2:0]     r_res_co, n_res_co;
    logic           r_out_valid;
    logic [7:0]     r_out_ch;
    logic [2:0]     r_out_co;
    logic [6:0]     r_out_row;
    logic [7:0]     r_out_col;

    logic [CW-1:0]  w_eff;
    logic [RW:0]    w_row1;
    logic           w_scroll;
    logic           w_nl;
    logic [RW:0]    w_base1;
    logic           w_bs_do;
    logic [RW-1:0]  w_bs_row;
    logic [CW-1:0]  w_bs_col;
    logic [RW-1:0]  w_lrow;
    logic [RW:0]    w_psum;
    logic [RW-1:0]  w_prow;
    logic           w_rd_ok;
    logic           w_we_ch, w_we_co;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [7:0]     w_wch, w_rch;
    logic [2:0]     w_wco, w_rco;
    logic           w_load;

    assign w_eff = ({1'b0, i_vis_cols} < 9'(COLS)) ? CW'(i_vis_cols) : CW'(COLS);
    assign w_row1 = {1'b0, r_row} + (RW+1)'(1);
    assign w_scroll = (8'(w_row1) >= {1'b0, i_vis_rows}) || (w_row1 >= (RW+1)'(ROWS));
    assign w_nl = (r_ch == ttcb_pkg::CH_NL) || (r_col >= w_eff);
    assign w_base1 = {1'b0, r_base} + (RW+1)'(1);

    always_comb begin
        w_bs_do  = 1'b1;
        w_bs_row = r_row;
        w_bs_col = r_col;
        if (r_col != '0) begin
            w_bs_col = r_col - CW'(1);
        end else if (r_row != '0) begin
            w_bs_row = r_row - RW'(1);
            w_bs_col = (w_eff != '0) ? w_eff - CW'(1) : '0;
        end else begin
            w_bs_do = 1'b0;
        end
    end

    // map a logical row onto the rotated physical row
    always_comb begin
        case (r_state)
            S_BS:    w_lrow = w_bs_row;
            S_RD:    w_lrow = r_op.rd_row[RW-1:0];
            default: w_lrow = r_row;
        endcase
        w_psum = {1'b0, w_lrow} + {1'b0, r_base};
        w_prow = (w_psum >= (RW+1)'(ROWS)) ? RW'(w_psum - (RW+1)'(ROWS)) : w_psum[RW-1:0];
    end

    assign w_rd_ok = ({1'b0, r_op.rd_row} < 8'(ROWS)) && ({1'b0, r_op.rd_col} < 9'(COLS));
    assign w_raddr = {w_prow, r_op.rd_col[CAW-1:0]};
    assign w_load  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_we_ch = 1'b0;
        w_we_co = 1'b0;
        w_wch   = ttcb_pkg::CH_SP;
        w_wco   = ttcb_pkg::PEN_DEFAULT;
        w_waddr = {w_prow, r_col[CAW-1:0]};
        case (r_state)
            S_SWEEP: begin
                w_we_ch = 1'b1;
                w_we_co = 1'b1;
                w_waddr = {r_sw_row, r_sw_col};
            end
            S_WR: begin
                w_we_ch = ({1'b0, r_col} < (CW+1)'(COLS));
                w_we_co = w_we_ch;
                w_wch   = r_ch;
                w_wco   = r_op.pen;
            end
            S_BS: begin
                w_we_ch = w_bs_do;
                w_waddr = {w_prow, w_bs_col[CAW-1:0]};
            end
            default: begin
                w_we_ch = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_op     = r_op;
        n_ch     = r_ch;
        n_main   = r_main;
        n_row    = r_row;
        n_col    = r_col;
        n_base   = r_base;
        n_sw_row = r_sw_row;
        n_sw_col = r_sw_col;
        n_sw_all = r_sw_all;
        n_init   = r_init;
        n_res_ch = r_res_ch;
        n_res_co = r_res_co;
        o_pop    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_op     = i_op;
                    n_res_ch = '0;
                    n_res_co = '0;
                    if (i_op.pre_esc) begin
                        n_ch    = ttcb_pkg::CH_ESC;
                        n_main  = (i_op.kind == ttcb_pkg::OP_PUT);
                        n_state = S_CHAR;
                    end else begin
                        n_main = 1'b0;
                        n_ch   = i_op.data;
                        case (i_op.kind)
                            ttcb_pkg::OP_PUT:  n_state = S_CHAR;
                            ttcb_pkg::OP_BS:   n_state = S_BS;
                            ttcb_pkg::OP_READ: n_state = S_RD;
                            ttcb_pkg::OP_CLR: begin
                                n_sw_row = '0;
                                n_sw_col = '0;
                                n_sw_all = 1'b1;
                                n_base   = '0;
                                n_row    = '0;
                                n_col    = '0;
                                n_ret    = S_OUT;
                                n_state  = S_SWEEP;
                            end
                            default: n_state = S_OUT;
                        endcase
                    end
                end
            end
            S_CHAR: begin
                if (w_nl) begin
                    n_col = '0;
                    if (w_scroll) begin
                        // rotate one row up; the old top row becomes the blank bottom
                        n_base   = (w_base1 == (RW+1)'(ROWS)) ? '0 : w_base1[RW-1:0];
                        n_sw_row = r_base;
                        n_sw_col = '0;
                        n_sw_all = 1'b0;
                        n_ret    = (r_ch == ttcb_pkg::CH_NL) ? S_NEXT : S_WR;
                        n_state  = S_SWEEP;
                    end else begin
                        n_row   = w_row1[RW-1:0];
                        n_state = (r_ch == ttcb_pkg::CH_NL) ? S_NEXT : S_WR;
                    end
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                n_col   = r_col + CW'(1);
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_main) begin
                    n_main  = 1'b0;
                    n_ch    = r_op.data;
                    n_state = S_CHAR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SWEEP: begin
                if (r_sw_col == CAW'(COLS - 1)) begin
                    n_sw_col = '0;
                    if (r_sw_all && r_sw_row != RW'(ROWS - 1)) begin
                        n_sw_row = r_sw_row + RW'(1);
                    end else begin
                        n_init  = 1'b0;
                        n_state = r_ret;
                    end
                end else begin
                    n_sw_col = r_sw_col + CAW'(1);
                end
            end
            S_BS: begin
                n_row   = w_bs_row;
                n_col   = w_bs_col;
                n_state = S_OUT;
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                n_res_ch = w_rd_ok ? w_rch : '0;
                n_res_co = w_rd_ok ? w_rco : '0;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_ret       <= S_IDLE;
            r_main      <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_sw_row    <= '0;
            r_sw_col    <= '0;
            r_sw_all    <= 1'b1;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_main   <= n_main;
            r_row    <= n_row;
            r_col    <= n_col;
            r_base   <= n_base;
            r_sw_row <= n_sw_row;
            r_sw_col <= n_sw_col;
            r_sw_all <= n_sw_all;
            r_init   <= n_init;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_ch     <= n_ch;
        r_res_ch <= n_res_ch;
        r_res_co <= n_res_co;
        if (w_load) begin
            r_out_ch  <= r_res_ch;
            r_out_co  <= r_res_co;
            r_out_row <= 7'(r_row);
            r_out_col <= 8'(r_col);
        end
    end

    ttcb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_ch),
        .i_waddr (w_waddr),
        .i_wdata (w_wch),
        .i_raddr (w_raddr),
        .o_rdata (w_rch)
    );

    ttcb_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_co),
        .i_waddr (w_waddr),
        .i_wdata (w_wco),
        .i_raddr (w_raddr),
        .o_rdata (w_rco)
    );

    assign o_status.init_busy = r_init;
    assign o_out.valid        = r_out_valid;
    assign o_out.cell_char    = r_out_ch;
    assign o_out.cell_color   = r_out_co;
    assign o_out.cursor_row   = r_out_row;
    assign o_out.cursor_col   = r_out_col;

    `ASSERT_IMP(a_row_range, i_clk, i_rst_n, 1'b1, {1'b0, r_row} < (RW+1)'(ROWS))
    `ASSERT_NXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state != S_IDLE)
endmodule

// ----- design/text_terminal_cell_buffer_core.sv -----
// Top level of the terminal cell buffer: config registers, front, queue, back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Character-cell terminal store with an escape-sequence color parser.
// Input channel i_in carries one command per transfer: put byte, backspace,
// clear, or read cell. Output channel o_out returns exactly one result per
// command: the read cell (zero for other commands) and the cursor afterward.
// An APB port holds visible_cols (address 0) and visible_rows (address 4);
// write them only while the block is idle.
// Sequencing: a plain put steps from the queue through the character check,
// write and next states to the result; a put that also prints a pending lone
// escape runs those steps twice. Backspace blanks the previous cell, if any,
// and moves the cursor in its own state; a read issues a cell RAM read, then
// waits for the registered data. A scroll adds a sweep that blanks the new
// bottom row; clear sweeps the whole store. A two-entry queue lets the front
// take items while the back works. Reset: the back sweeps all ROWS*COLS
// cells to white spaces and holds i_in.ready low meanwhile.
// A stalled receiver holds the result register; the back then stops after
// finishing one more item, and the queue fills before i_in.ready drops.
module text_terminal_cell_buffer_core #(
    parameter int ROWS = ttcb_pkg::DEF_ROWS,
    parameter int COLS = ttcb_pkg::DEF_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttcb_in_if.sink     i_in,
    ttcb_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic REG_COLS = 1'b0;

    logic                 r_vis_cols_q;
    logic [7:0]           r_vis_cols;
    logic [6:0]           r_vis_rows;
    logic                 w_push, w_pop, w_full, w_empty;
    ttcb_pkg::t_op        w_push_op, w_pop_op;
    ttcb_pkg::t_bk_status w_status;

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_cols   <= 8'd160;
            r_vis_rows   <= 7'd80;
            r_vis_cols_q <= 1'b0;
        end else begin
            r_vis_cols_q <= 1'b0;
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_COLS) begin
                    r_vis_cols   <= pwdata[7:0];
                    r_vis_cols_q <= 1'b1;
                end else begin
                    r_vis_rows <= pwdata[6:0];
                end
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COLS) ? {24'd0, r_vis_cols} : {25'd0, r_vis_rows};

    ttcb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (w_status),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    ttcb_fifo #(.WIDTH($bits(ttcb_pkg::t_op))) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_op)
    );

    ttcb_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vis_cols (r_vis_cols),
        .i_vis_rows (r_vis_rows),
        .i_q_empty  (w_empty),
        .i_op       (w_pop_op),
        .o_pop      (w_pop),
        .o_status   (w_status),
        .o_out      (o_out)
    );

    `ASSERT_IMP(a_init_blocks_in, i_clk, i_rst_n, w_status.init_busy, !i_in.ready)
    `ASSERT_NXT(a_cols_write_lands, i_clk, i_rst_n, r_vis_cols_q, $stable(r_vis_cols) || !r_vis_cols_q)
endmodule
